@@ rtl/pq_adc_topk_search_unit_assert.svh @@
// Assertion macros for the PQ ADC top-k search unit
`ifndef PQ_ADC_TOPK_SEARCH_UNIT_ASSERT_SVH
`define PQ_ADC_TOPK_SEARCH_UNIT_ASSERT_SVH
`define PQA_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PQA_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/pqa_pkg.sv @@
// Package: types and constants of the PQ ADC top-k search unit
package pqa_pkg;
    localparam int MaxSub = 16;
    localparam int CodeBits = 8;
    localparam int MaxRes = 16;
    localparam int SubW = $clog2(MaxSub);
    localparam int ResW = $clog2(MaxRes);
    localparam int TabDepth = MaxSub * (1 << CodeBits);
    localparam int TabAw = $clog2(TabDepth);
    localparam logic [23:0] IdTop = 24'hFFFFFF;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0, CMD_CODE = 2'd1, CMD_START = 2'd2, CMD_FINISH = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_SUB_COUNT = 2'd0;
    localparam logic [1:0] REG_RESULT_COUNT = 2'd1;
    localparam logic [1:0] REG_KEEP_LARGEST = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] sub_index;
        logic [7:0] code;
        logic signed [31:0] table_value;
    } t_in;

    typedef struct packed {
        logic [3:0] rank;
        logic [23:0] vector_id;
        logic signed [39:0] distance;
        logic valid_res;
        logic last;
    } t_out;

    typedef struct packed {
        logic add;
        logic clear;
        logic emit;
        logic [ResW-1:0] emit_idx;
        logic emit_last;
    } t_cmdbus;

    function automatic logic [4:0] clamp_count(input logic [4:0] v, input logic [6:0] top);
        logic [4:0] r;
        begin
            r = v;
            if (v == 5'd0) r = 5'd1;
            if ({2'b00, v} > top) r = top[4:0];
            return r;
        end
    endfunction
endpackage

@@ rtl/pqa_ram.sv @@
// Generic single-port-write, registered-read RAM
module pqa_ram #(
    parameter int Width = 32,
    parameter int Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/pqa_ctrl.sv @@
// Controller: sequences commands, lookups and finish readout
module pqa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_cmd,
    input  logic [4:0]        i_result_count,
    output pqa_pkg::t_cmdbus  o_bus,
    output logic              o_valid,
    input  logic              i_out_stall
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_LOOK = 4'b0010, S_EMIT = 4'b0100, S_WAIT = 4'b1000
    } t_state;
    t_state r_state, n_state;
    logic [pqa_pkg::ResW:0] r_idx, n_idx;
    logic [4:0] k;
    logic take;

    assign k = pqa_pkg::clamp_count(i_result_count, 7'(pqa_pkg::MaxRes));
    assign o_stall = (r_state != S_IDLE);
    assign take = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        o_bus = '0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_cmd)
                        pqa_pkg::CMD_CODE: n_state = S_LOOK;
                        pqa_pkg::CMD_START: o_bus.clear = 1'b1;
                        pqa_pkg::CMD_FINISH: begin
                            n_state = S_EMIT;
                            n_idx = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOK: begin
                o_bus.add = 1'b1;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                o_bus.emit = 1'b1;
                o_bus.emit_idx = r_idx[pqa_pkg::ResW-1:0];
                o_bus.emit_last = (6'(r_idx) + 6'd1 == 6'(k));
                n_state = S_WAIT;
            end
            S_WAIT: begin
                o_valid = 1'b1;
                if (!i_out_stall) begin
                    n_idx = r_idx + 1'b1;
                    n_state = (6'(r_idx) + 6'd1 == 6'(k)) ? S_IDLE : S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end
endmodule

@@ rtl/pqa_dp.sv @@
// Datapath: table RAM, accumulator, sorted best-list cells, result register
module pqa_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  pqa_pkg::t_in     i_in,
    input  pqa_pkg::t_cmdbus i_bus,
    input  logic [4:0]       i_sub_count,
    input  logic             i_keep_largest,
    output pqa_pkg::t_out    o_res
);
    localparam int Cb = pqa_pkg::CodeBits;
    localparam int Mr = pqa_pkg::MaxRes;
    logic [pqa_pkg::TabAw-1:0] waddr, raddr;
    logic [31:0] rdata;
    logic we;
    logic [Cb-1:0] col;
    logic [pqa_pkg::SubW-1:0] row_r;
    logic [4:0] m;
    logic signed [39:0] r_sum, n_sum;
    logic [4:0] r_pos;
    logic [23:0] r_cnt;
    logic signed [39:0] r_bs [Mr];
    logic [23:0] r_bi [Mr];
    logic [Mr-1:0] r_bf;
    logic [Mr-1:0] hit;
    logic [Mr-1:0] ahead;
    logic do_offer;

    assign col = i_in.code[Cb-1:0];
    assign we = i_take && (i_in.cmd == pqa_pkg::CMD_LOAD) && ({1'b0, i_in.sub_index} < 5'(pqa_pkg::MaxSub));
    assign waddr = pqa_pkg::TabAw'({i_in.sub_index, col});
    assign row_r = (r_pos < 5'(pqa_pkg::MaxSub)) ? r_pos[pqa_pkg::SubW-1:0] : pqa_pkg::SubW'(pqa_pkg::MaxSub - 1);
    assign raddr = pqa_pkg::TabAw'({row_r, col});

    pqa_ram #(.Width(32), .Depth(pqa_pkg::TabDepth)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_in.table_value),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign m = pqa_pkg::clamp_count(i_sub_count, 7'(pqa_pkg::MaxSub));
    assign n_sum = r_sum + 40'(signed'(rdata));
    assign do_offer = i_bus.add && ((r_pos + 5'd1) >= m);

    always_comb begin
        for (int i = 0; i < Mr; i++) begin
            hit[i] = !r_bf[i] || (i_keep_largest ? (n_sum > r_bs[i]) : (n_sum < r_bs[i]));
        end
        ahead[0] = 1'b0;
        for (int i = 1; i < Mr; i++) begin
            ahead[i] = ahead[i-1] || hit[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_bus.clear) begin
            r_sum <= '0;
            r_pos <= '0;
            r_cnt <= '0;
            r_bf <= '0;
        end else if (i_bus.add) begin
            if (do_offer) begin
                r_sum <= '0;
                r_pos <= '0;
                if (r_cnt != pqa_pkg::IdTop) r_cnt <= r_cnt + 24'd1;
                for (int i = 0; i < Mr; i++) begin
                    if (ahead[i]) begin
                        r_bs[i] <= r_bs[(i == 0) ? 0 : i-1];
                        r_bi[i] <= r_bi[(i == 0) ? 0 : i-1];
                        r_bf[i] <= r_bf[(i == 0) ? 0 : i-1];
                    end else if (hit[i]) begin
                        r_bs[i] <= n_sum;
                        r_bi[i] <= r_cnt;
                        r_bf[i] <= 1'b1;
                    end
                end
            end else begin
                r_sum <= n_sum;
                r_pos <= r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bus.emit) begin
            o_res.rank <= 4'(i_bus.emit_idx);
            o_res.vector_id <= r_bf[i_bus.emit_idx] ? r_bi[i_bus.emit_idx] : 24'd0;
            o_res.distance <= r_bf[i_bus.emit_idx] ? r_bs[i_bus.emit_idx] : 40'sd0;
            o_res.valid_res <= r_bf[i_bus.emit_idx];
            o_res.last <= i_bus.emit_last;
        end
    end
endmodule

@@ rtl/pq_adc_topk_search_unit.sv @@
// Top level of the PQ ADC top-k search unit
//  channel | direction | handshake
//  in      | input     | i_in_valid / o_in_stall, payload i_in
//  out     | output    | o_out_valid / i_out_stall, payload o_out
//  cfg     | input     | i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
// Load and start: taken in idle. Sub-code: table RAM read, then add and list insert.
// Finish: result_count results (clamped 1..16), each registered, then held on stall.
// Reset is synchronous; the list starts empty; the table is undefined until loaded.
module pq_adc_topk_search_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pqa_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pqa_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    logic [4:0] r_sub_count, r_result_count;
    logic r_keep_largest;
    pqa_pkg::t_cmdbus bus;
    logic take;

    assign o_cfg_ready = 1'b1;
    assign take = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_count <= 5'd8;
            r_result_count <= 5'd10;
            r_keep_largest <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pqa_pkg::REG_SUB_COUNT: r_sub_count <= i_cfg_data[4:0];
                pqa_pkg::REG_RESULT_COUNT: r_result_count <= i_cfg_data[4:0];
                pqa_pkg::REG_KEEP_LARGEST: r_keep_largest <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    pqa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in_valid), .o_stall(o_in_stall),
        .i_cmd(i_in.cmd), .i_result_count(r_result_count), .o_bus(bus),
        .o_valid(o_out_valid), .i_out_stall(i_out_stall)
    );

    pqa_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_in(i_in), .i_bus(bus),
        .i_sub_count(r_sub_count), .i_keep_largest(r_keep_largest), .o_res(o_out)
    );
endmodule

@@ rtl/pqa_checker.sv @@
// Port-level checker for the PQ ADC top-k search unit, with bind
`include "pq_adc_topk_search_unit_assert.svh"
module pqa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input pqa_pkg::t_out o_out
);
    `PQA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out))
    `PQA_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `PQA_ASSERT_IMP(a_fill, i_clk, i_rst_n, o_out_valid && !o_out.valid_res, o_out.distance == 40'sd0 && o_out.vector_id == 24'd0)
    `PQA_ASSERT_NXT(a_next_rank, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out.last, o_in_stall)
endmodule

bind pq_adc_topk_search_unit pqa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
);
